>>> rtl/esd_pkg.sv
package esd_pkg;

  // Width of the running byte counter; the shown count is its low bits
  localparam int COUNT_BITS  = 12;
  localparam int SHOW_BITS   = 12;
  localparam int MAX_RESULTS = 5;
  localparam int NUM_BITS    = $clog2(MAX_RESULTS + 1);

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_QM    = 8'h3F;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_V     = 8'h76;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_LU    = 8'h75;
  localparam logic [7:0] CH_UU    = 8'h55;
  localparam logic [7:0] CH_8     = 8'h38;
  localparam logic [7:0] CH_9     = 8'h39;

  // Control codes produced by the simple escapes
  localparam logic [7:0] CC_BEL   = 8'h07;
  localparam logic [7:0] CC_BS    = 8'h08;
  localparam logic [7:0] CC_FF    = 8'h0C;
  localparam logic [7:0] CC_LF    = 8'h0A;
  localparam logic [7:0] CC_CR    = 8'h0D;
  localparam logic [7:0] CC_HT    = 8'h09;
  localparam logic [7:0] CC_VT    = 8'h0B;

  // Hex escape kinds
  localparam logic [1:0] HEX_X    = 2'd0;
  localparam logic [1:0] HEX_LU   = 2'd1;
  localparam logic [1:0] HEX_UU   = 2'd2;

  typedef struct packed {
    logic [7:0] data;
    logic       is_end;
  } res_t;

  // Results produced by one request, first in item[0]
  typedef struct packed {
    res_t [MAX_RESULTS-1:0] item;
    logic [NUM_BITS-1:0]    num;
  } burst_t;

endpackage

>>> rtl/esd_decode.sv
module esd_decode (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  input  logic [7:0]      in_byte,
  output esd_pkg::burst_t burst
);
  import esd_pkg::*;

  typedef enum logic [1:0] {
    M_IDLE,
    M_ESC,
    M_HEX,
    M_OCT
  } mode_t;

  mode_t       mode, mode_next;
  logic [3:0]  digits_left, digits_left_next;
  logic [1:0]  hex_kind, hex_kind_next;
  logic [31:0] hex_value, hex_value_next;
  logic        hex_stopped, hex_stopped_next;
  logic [7:0]  octal_value, octal_value_next;

  // Hex escape length: low byte up to top nonzero one; x gives 1 byte, u at most 2
  function automatic logic [2:0] hex_len(logic [1:0] kind, logic [31:0] v);
    logic [2:0] len;
    len = 3'd1;
    if (kind == HEX_X) begin
      len = 3'd1;
    end else if (kind == HEX_LU) begin
      len = (v[31:8] != '0) ? 3'd2 : 3'd1;
    end else begin
      if (v[31:24] != '0)      len = 3'd4;
      else if (v[31:16] != '0) len = 3'd3;
      else if (v[31:8] != '0)  len = 3'd2;
    end
    return len;
  endfunction

  // Decode one request into its burst of results and the next state
  always_comb begin
    res_t [MAX_RESULTS-1:0] it;
    logic [NUM_BITS-1:0]    n;
    logic                   is_hex;
    logic [3:0]             dig;
    logic [3:0]             dl;
    logic [31:0]            fv;
    logic [2:0]             flen;
    logic                   do_flush;
    logic                   do_plain;
    logic                   do_end;

    it               = '0;
    n                = '0;
    mode_next        = mode;
    digits_left_next = digits_left;
    hex_kind_next    = hex_kind;
    hex_value_next   = hex_value;
    hex_stopped_next = hex_stopped;
    octal_value_next = octal_value;
    do_flush         = 1'b0;
    do_plain         = 1'b0;
    do_end           = 1'b0;
    fv               = hex_value;
    dl               = digits_left;

    // Hex digit value of the incoming character
    is_hex = 1'b1;
    dig    = 4'd0;
    if (in_byte inside {[8'h30:8'h39]}) begin
      dig = in_byte[3:0];
    end else if (in_byte inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      dig = 4'(in_byte[2:0] + 3'd1) + 4'd8;
    end else begin
      is_hex = 1'b0;
    end

    case (mode)
      M_ESC: begin
        mode_next = M_IDLE;
        case (in_byte)
          CH_NUL: do_end = 1'b1;
          CH_BSL, CH_SQ, CH_DQ, CH_QM: begin
            it[n] = '{data: in_byte, is_end: 1'b0};
            n = n + 1'b1;
          end
          CH_A: begin it[n] = '{data: CC_BEL, is_end: 1'b0}; n = n + 1'b1; end
          CH_B: begin it[n] = '{data: CC_BS,  is_end: 1'b0}; n = n + 1'b1; end
          CH_F: begin it[n] = '{data: CC_FF,  is_end: 1'b0}; n = n + 1'b1; end
          CH_N: begin it[n] = '{data: CC_LF,  is_end: 1'b0}; n = n + 1'b1; end
          CH_R: begin it[n] = '{data: CC_CR,  is_end: 1'b0}; n = n + 1'b1; end
          CH_T: begin it[n] = '{data: CC_HT,  is_end: 1'b0}; n = n + 1'b1; end
          CH_V: begin it[n] = '{data: CC_VT,  is_end: 1'b0}; n = n + 1'b1; end
          CH_LX, CH_LU, CH_UU: begin
            mode_next        = M_HEX;
            hex_value_next   = '0;
            hex_stopped_next = 1'b0;
            if (in_byte == CH_LX) begin
              hex_kind_next = HEX_X;  digits_left_next = 4'd2;
            end else if (in_byte == CH_LU) begin
              hex_kind_next = HEX_LU; digits_left_next = 4'd4;
            end else begin
              hex_kind_next = HEX_UU; digits_left_next = 4'd8;
            end
          end
          CH_8, CH_9: begin
            // Emit a zero byte, then keep the digit as plain text
            it[n] = '{data: 8'h00, is_end: 1'b0};
            n = n + 1'b1;
            it[n] = '{data: in_byte, is_end: 1'b0};
            n = n + 1'b1;
          end
          default: begin
            if (in_byte inside {[8'h30:8'h37]}) begin
              mode_next        = M_OCT;
              octal_value_next = {5'd0, in_byte[2:0]};
            end
          end
        endcase
      end
      M_HEX: begin
        if (in_byte == CH_NUL) begin
          // End inside a hex escape: flush the value so far, then terminate
          fv       = hex_value;
          do_flush = 1'b1;
          do_end   = 1'b1;
        end else begin
          if (!hex_stopped) begin
            if (is_hex) hex_value_next = {hex_value[27:0], dig};
            else        hex_stopped_next = 1'b1;
          end
          dl = (digits_left == 4'd0) ? 4'd0 : digits_left - 4'd1;
          digits_left_next = dl;
          fv = hex_value_next;
          if (dl == 4'd0) do_flush = 1'b1;
        end
      end
      M_OCT: begin
        if (in_byte inside {[8'h30:8'h37]}) begin
          octal_value_next = {octal_value[4:0], 3'd0} + {5'd0, in_byte[2:0]};
        end else begin
          mode_next = M_IDLE;
          it[n] = '{data: octal_value, is_end: 1'b0};
          n = n + 1'b1;
          do_plain = 1'b1;
        end
      end
      default: begin
        mode_next = M_IDLE;
        do_plain  = 1'b1;
      end
    endcase

    // Emit the hex value, low byte first
    flen = hex_len(hex_kind, fv);
    if (do_flush) begin
      mode_next = M_IDLE;
      for (int k = 0; k < 4; k++) begin
        if (3'(k) < flen) begin
          it[n] = '{data: fv[8*k +: 8], is_end: 1'b0};
          n = n + 1'b1;
        end
      end
    end

    // Plain text handling
    if (do_plain) begin
      if (in_byte == CH_NUL) begin
        do_end = 1'b1;
      end else if (in_byte == CH_BSL) begin
        mode_next = M_ESC;
      end else begin
        it[n] = '{data: in_byte, is_end: 1'b0};
        n = n + 1'b1;
      end
    end

    // Terminator closes the string
    if (do_end) begin
      mode_next = M_IDLE;
      it[n] = '{data: 8'h00, is_end: 1'b1};
      n = n + 1'b1;
    end

    burst.item = it;
    burst.num  = n;
  end

  // Hold decoder state; advance on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= M_IDLE;
      digits_left <= '0;
      hex_kind    <= '0;
      hex_value   <= '0;
      hex_stopped <= 1'b0;
      octal_value <= '0;
    end else if (take) begin
      mode        <= mode_next;
      digits_left <= digits_left_next;
      hex_kind    <= hex_kind_next;
      hex_value   <= hex_value_next;
      hex_stopped <= hex_stopped_next;
      octal_value <= octal_value_next;
    end
  end

endmodule

>>> rtl/esd_emit.sv
module esd_emit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           load,
  input  esd_pkg::burst_t                burst,
  output logic                           ready,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_byte,
  output logic                           is_end,
  output logic [esd_pkg::SHOW_BITS-1:0]  byte_count
);
  import esd_pkg::*;

  localparam int PEND = MAX_RESULTS - 1;

  res_t [PEND-1:0]         pend;
  logic [NUM_BITS-1:0]     pend_num;
  logic [COUNT_BITS-1:0]   count;
  logic [COUNT_BITS-1:0]   count_inc;
  logic                    free;
  logic                    do_load;
  res_t                    src;

  // Output register free when empty or being taken
  assign free  = !out_valid || !out_stall;
  assign ready = free && (pend_num == '0);

  // Pick the next result for the output register
  always_comb begin
    if (load) begin
      src     = burst.item[0];
      do_load = (burst.num != '0);
    end else begin
      src     = pend[0];
      do_load = free && (pend_num != '0);
    end
    count_inc = (count == '1) ? count : count + 1'b1;
  end

  // Hold control state: output valid, pending depth, running count
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend_num  <= '0;
      count     <= '0;
    end else begin
      if (do_load) begin
        out_valid <= 1'b1;
        count     <= src.is_end ? '0 : count_inc;
      end else if (free) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        pend_num <= (burst.num == '0) ? '0 : burst.num - 1'b1;
      end else if (free && pend_num != '0) begin
        pend_num <= pend_num - 1'b1;
      end
    end
  end

  // Load payload and shift the pending queue
  always_ff @(posedge clk) begin
    if (do_load) begin
      out_byte   <= src.data;
      is_end     <= src.is_end;
      byte_count <= src.is_end ? SHOW_BITS'(count) : SHOW_BITS'(count_inc);
    end
    if (load) begin
      for (int i = 0; i < PEND; i++) pend[i] <= burst.item[i+1];
    end else if (free && pend_num != '0) begin
      for (int i = 0; i < PEND-1; i++) pend[i] <= pend[i+1];
    end
  end

endmodule

>>> rtl/escape_sequence_decoder.sv
// Output is registered: a request's first result loads as the request is taken.
// Throughput: one request per cycle while each request yields at most one result
//   and no output stall; a request yielding k results (up to five) stalls input
//   while the single output register drains its pending queue one per cycle.
// Reset: synchronous, active high; decoder returns to plain text, count to zero,
//   output and pending queue empty.
module escape_sequence_decoder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    out_byte,
  output logic                          is_end,
  output logic [esd_pkg::SHOW_BITS-1:0] byte_count
);
  import esd_pkg::*;

  burst_t burst;
  logic   ready;
  logic   take;

  assign in_stall = !ready;
  assign take     = in_valid && ready;

  esd_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .in_byte (in_byte),
    .burst   (burst)
  );

  esd_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .load       (take),
    .burst      (burst),
    .ready      (ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .is_end     (is_end),
    .byte_count (byte_count)
  );

endmodule

>>> rtl/esd_checker.sv
module esd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [7:0]                    in_byte,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [7:0]                    out_byte,
  input logic                          is_end,
  input logic [esd_pkg::SHOW_BITS-1:0] byte_count
);
  import esd_pkg::*;

  // Output empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // Terminator carries a zero byte
  a_end_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_end |-> out_byte == 8'h00)
    else $error("terminator with nonzero byte");

  // Count advances by one between consecutive data results, saturating at its maximum
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !is_end |=>
      !out_valid || is_end || $past(byte_count) == '1 ||
      byte_count == SHOW_BITS'($past(byte_count) + 1'b1))
    else $error("byte count did not advance by one");

  // Stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(is_end))
    else $error("stalled result changed");

  // Stalled request holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(in_byte))
    else $error("stalled request changed");

endmodule

bind escape_sequence_decoder esd_checker u_esd_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .in_byte    (in_byte),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_byte   (out_byte),
  .is_end     (is_end),
  .byte_count (byte_count)
);
